>>> rtl/mssd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment display driver package
// Shared types, constants and helper functions for the multiplexed
// eight-digit decimal display driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

    // Item kinds carried on the input side-band.
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_SCAN = 1'b1
    } req_t;

    localparam int unsigned DIGITS     = 8;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned CODE_W     = 5;
    localparam int unsigned LINES_W    = 8;
    localparam int unsigned PROD_W     = 33;

    localparam logic [CODE_W-1:0]  BLANK_CODE = 5'd16;
    localparam logic [LINES_W-1:0] LINES_OFF  = 8'hff;

    // Reciprocal constants, exact for every 16-bit value.
    localparam logic [16:0] DIV10_MAGIC   = 17'd52429;
    localparam logic [16:0] DIV100_MAGIC  = 17'd83887;
    localparam logic [16:0] DIV1000_MAGIC = 17'd67109;

    // Input item as unpacked from the stream.
    typedef struct packed {
        req_t                 req_type;
        logic [POS_W-1:0]     position;
        logic [VALUE_W-1:0]   first_value;
        logic [VALUE_W-1:0]   second_value;
    } in_item_t;

    // One value with its quotients by 10, 100 and 1000.
    typedef struct packed {
        logic [VALUE_W-1:0] val;
        logic [12:0]        q10;
        logic [9:0]         q100;
        logic [6:0]         q1000;
    } val_q_t;

    // Item after the quotient stage.
    typedef struct packed {
        req_t             req_type;
        logic [POS_W-1:0] position;
        val_q_t           first_q;
        val_q_t           second_q;
    } mid_item_t;

    // Quotients by multiplication with scaled reciprocals.
    function automatic val_q_t split_value(input logic [VALUE_W-1:0] v);
        logic [PROD_W-1:0] p10;
        logic [PROD_W-1:0] p100;
        logic [PROD_W-1:0] p1000;
        val_q_t            r;
        p10     = PROD_W'(v) * PROD_W'(DIV10_MAGIC);
        p100    = PROD_W'(v) * PROD_W'(DIV100_MAGIC);
        p1000   = PROD_W'(v) * PROD_W'(DIV1000_MAGIC);
        r.val   = v;
        r.q10   = p10[31:19];
        r.q100  = p100[32:23];
        r.q1000 = p1000[32:26];
        return r;
    endfunction

    // Remainder digit x - 10*q, worked in the low four bits only.
    function automatic logic [3:0] digit_of(input logic [3:0] x, input logic [3:0] q);
        logic [6:0] t;
        t = {q, 3'b000} + {2'b00, q, 1'b0};
        return x - t[3:0];
    endfunction

    // Segment pattern for a display code; unknown codes are blank.
    function automatic logic [LINES_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
        logic [LINES_W-1:0] s;
        case (code)
            5'd0:    s = 8'hc0;
            5'd1:    s = 8'hf9;
            5'd2:    s = 8'ha4;
            5'd3:    s = 8'hb0;
            5'd4:    s = 8'h99;
            5'd5:    s = 8'h92;
            5'd6:    s = 8'h82;
            5'd7:    s = 8'hf8;
            5'd8:    s = 8'h80;
            5'd9:    s = 8'h90;
            5'd10:   s = 8'h88;
            5'd11:   s = 8'h83;
            5'd12:   s = 8'hc6;
            5'd13:   s = 8'ha1;
            5'd14:   s = 8'h86;
            5'd15:   s = 8'h8e;
            default: s = LINES_OFF;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/mssd_split.sv
// ----------------------------------------------------------------------------
// Input and quotient stages
// Registers the incoming item, then registers the quotients of both values
// by 10, 100 and 1000. Each stage holds its item until the next takes it.
// ----------------------------------------------------------------------------
module mssd_split (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mssd_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mssd_pkg::mid_item_t  out_item
);
    import mssd_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      mid_valid_reg;
    mid_item_t mid_item_reg;
    logic      mid_ready;
    mid_item_t mid_item_next;

    // Each stage may load when it is empty or its item moves on.
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;

    // Quotients of the registered item.
    always_comb
    begin
        mid_item_next.req_type = in_item_reg.req_type;
        mid_item_next.position = in_item_reg.position;
        mid_item_next.first_q  = split_value(in_item_reg.first_value);
        mid_item_next.second_q = split_value(in_item_reg.second_value);
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (mid_ready)
            begin
                mid_valid_reg <= in_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
        if (mid_ready && in_valid_reg)
        begin
            mid_item_reg <= mid_item_next;
        end
    end

    assign out_valid = mid_valid_reg;
    assign out_item  = mid_item_reg;

endmodule

>>> rtl/mssd_scan.sv
// ----------------------------------------------------------------------------
// Display state and result stage
// Holds the eight display codes and the digit and segment lines. A load
// item stores new codes; a scan item moves the lit digit and looks up its
// segment pattern. The lines themselves form the result register.
// ----------------------------------------------------------------------------
module mssd_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  mssd_pkg::mid_item_t          in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mssd_pkg::LINES_W-1:0] digit_enables_n,
    output logic [mssd_pkg::LINES_W-1:0] segments_n
);
    import mssd_pkg::*;

    logic [CODE_W-1:0]  digit_codes_reg [DIGITS];
    logic [CODE_W-1:0]  digit_codes_next [DIGITS];
    logic [LINES_W-1:0] digit_lines_reg;
    logic [LINES_W-1:0] digit_lines_next;
    logic [LINES_W-1:0] segment_lines_reg;
    logic [LINES_W-1:0] segment_lines_next;
    logic               out_valid_reg;
    logic               accept;
    logic [POS_W-1:0]   prev_pos;
    logic [LINES_W-1:0] pos_mask;
    logic [LINES_W-1:0] prev_mask;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign prev_pos  = in_item.position - POS_W'(1);
    assign pos_mask  = LINES_W'(1) << in_item.position;
    assign prev_mask = LINES_W'(1) << prev_pos;

    // Next state for the item at the input.
    always_comb
    begin
        digit_codes_next   = digit_codes_reg;
        digit_lines_next   = digit_lines_reg;
        segment_lines_next = segment_lines_reg;
        case (in_item.req_type)
            REQ_LOAD:
            begin
                digit_lines_next    = digit_lines_reg | 8'h80;
                segment_lines_next  = LINES_OFF;
                digit_codes_next[0] = BLANK_CODE;
                digit_codes_next[1] = {1'b0, digit_of(in_item.first_q.q100[3:0],
                                                      in_item.first_q.q1000[3:0])};
                digit_codes_next[2] = {1'b0, digit_of(in_item.first_q.q10[3:0],
                                                      in_item.first_q.q100[3:0])};
                digit_codes_next[3] = {1'b0, digit_of(in_item.first_q.val[3:0],
                                                      in_item.first_q.q10[3:0])};
                digit_codes_next[4] = BLANK_CODE;
                digit_codes_next[5] = {1'b0, digit_of(in_item.second_q.q100[3:0],
                                                      in_item.second_q.q1000[3:0])};
                digit_codes_next[6] = {1'b0, digit_of(in_item.second_q.q10[3:0],
                                                      in_item.second_q.q100[3:0])};
                digit_codes_next[7] = {1'b0, digit_of(in_item.second_q.val[3:0],
                                                      in_item.second_q.q10[3:0])};
            end
            REQ_SCAN:
            begin
                digit_lines_next   = (digit_lines_reg | prev_mask) & ~pos_mask;
                segment_lines_next = seg_pattern(digit_codes_reg[in_item.position]);
            end
            default:
            begin
                digit_lines_next = digit_lines_reg;
            end
        endcase
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                digit_codes_reg[i] <= '0;
            end
            digit_lines_reg   <= LINES_OFF;
            segment_lines_reg <= LINES_OFF;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (accept)
            begin
                digit_codes_reg   <= digit_codes_next;
                digit_lines_reg   <= digit_lines_next;
                segment_lines_reg <= segment_lines_next;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign digit_enables_n = digit_lines_reg;
    assign segments_n      = segment_lines_reg;

endmodule

>>> rtl/muxed_seven_segment_decimal_display_top.sv
// ----------------------------------------------------------------------------
// Multiplexed seven-segment decimal display driver
// Drives an eight-digit common-anode display with active-low digit enables
// and segments. Load items store two three-digit decimal values; scan items
// light one digit position.
//
// Channel   Signals               Contents (lowest bit first)
// s_axis    tvalid/tready/tdata   position[2:0], first_value[15:0],
//           tuser                 second_value[15:0]; tuser: req_type
// m_axis    tvalid/tready/tdata   digit_enables_n[7:0], segments_n[7:0]
//
// One item is accepted per cycle while s_axis_tready is high; each result
// passes the input, quotient and result registers before it is presented.
// Reset shows code zero in every digit and turns all lines off (0xff).
// A stalled result holds every stage that is full behind it; empty stages
// keep taking items, so s_axis_tready falls only when all three are full.
// ----------------------------------------------------------------------------
module muxed_seven_segment_decimal_display_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // position, first_value, second_value, zero fill
    input  logic [0:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // digit_enables_n, segments_n
);
    import mssd_pkg::*;

    in_item_t           in_item;
    mid_item_t          mid_item;
    logic               mid_valid;
    logic               mid_ready;
    logic [LINES_W-1:0] digit_enables_n;
    logic [LINES_W-1:0] segments_n;

    // Unpack the input item.
    always_comb
    begin
        in_item.req_type     = req_t'(s_axis_tuser[0]);
        in_item.position     = s_axis_tdata[2:0];
        in_item.first_value  = s_axis_tdata[18:3];
        in_item.second_value = s_axis_tdata[34:19];
    end

    mssd_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_item  (mid_item)
    );

    mssd_scan u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (mid_valid),
        .in_ready        (mid_ready),
        .in_item         (mid_item),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .digit_enables_n (digit_enables_n),
        .segments_n      (segments_n)
    );

    assign m_axis_tdata = {segments_n, digit_enables_n};

    // A load releases digit 7 and blanks the segments.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && mid_ready && mid_item.req_type == REQ_LOAD)
        |=> (m_axis_tdata[7] && m_axis_tdata[15:8] == LINES_OFF))
        else $error("load did not release digit 7 or blank the segments");

    // A scan enables the requested digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && mid_ready && mid_item.req_type == REQ_SCAN)
        |=> (m_axis_tdata[$past(mid_item.position)] == 1'b0))
        else $error("scan did not enable its digit");

    // The quotient by ten leaves a remainder below ten.
    assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid |-> ((17'(mid_item.first_q.val) - 17'(mid_item.first_q.q10) * 17'd10)
                       < 17'd10))
        else $error("quotient by ten out of range");

endmodule

>>> sim/muxed_seven_segment_decimal_display_top_test.sv
// ----------------------------------------------------------------------------
// Testbench for the multiplexed seven-segment decimal display driver
// A directed pass covers reset contents, every digit position, and value
// extremes. A random pass follows, made mostly of load-then-scan frames and
// some loose items. Random stalls are applied on both streams. Each result
// is checked against a line-state predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module muxed_seven_segment_decimal_display_top_test;

    import mssd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 380;
    localparam int FINAL_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 10;

    // Scoreboard: tracks the display state and holds the expected lines.
    class display_scoreboard;
        logic [CODE_W-1:0]  codes [DIGITS];
        logic [LINES_W-1:0] digit_lines;
        logic [LINES_W-1:0] segment_lines;
        logic [15:0]        pending_lines [$];
        int                 errors;
        int                 checked;

        function new();
            foreach (codes[i]) codes[i] = '0;
            digit_lines   = LINES_OFF;
            segment_lines = LINES_OFF;
            errors        = 0;
            checked       = 0;
        endfunction

        // Active-low pattern for a stored code; codes past the table are blank.
        function logic [LINES_W-1:0] pattern_for(logic [CODE_W-1:0] code);
            logic [LINES_W-1:0] patterns [16];
            patterns = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
                         8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e};
            if (code < 16)
                return patterns[code[3:0]];
            return LINES_OFF;
        endfunction

        // Store hundreds, tens and units of a value, mod 1000.
        function void store_decimal(int first, logic [VALUE_W-1:0] value);
            int unsigned rem;
            rem = value % 1000;
            codes[first]     = CODE_W'(rem / 100);
            codes[first + 1] = CODE_W'((rem / 10) % 10);
            codes[first + 2] = CODE_W'(rem % 10);
        endfunction

        // Update the display state for one accepted item and queue its lines.
        function void note_item(req_t req, logic [POS_W-1:0] pos,
                                logic [VALUE_W-1:0] left_value,
                                logic [VALUE_W-1:0] right_value);
            logic [POS_W-1:0] prev;
            if (req == REQ_LOAD)
            begin
                digit_lines[DIGITS-1] = 1'b1;
                segment_lines         = LINES_OFF;
                codes[0]              = BLANK_CODE;
                codes[4]              = BLANK_CODE;
                store_decimal(1, left_value);
                store_decimal(5, right_value);
            end
            else
            begin
                prev                = pos - 1'b1;
                digit_lines[prev]   = 1'b1;
                digit_lines[pos]    = 1'b0;
                segment_lines       = pattern_for(codes[pos]);
            end
            pending_lines.push_back({segment_lines, digit_lines});
        endfunction

        // Compare one result with the oldest expectation, field by field.
        function void check_lines(logic [15:0] data);
            logic [15:0] exp_lines;
            checked++;
            if (pending_lines.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Result with nothing expected: digits %h segments %h",
                             data[7:0], data[15:8]);
                return;
            end
            exp_lines = pending_lines.pop_front();
            if (data[7:0] !== exp_lines[7:0] || data[15:8] !== exp_lines[15:8])
            begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch on result %0d: digits exp %h got %h, ",
                              "segments exp %h got %h"},
                             checked, exp_lines[7:0], data[7:0],
                             exp_lines[15:8], data[15:8]);
            end
        endfunction

        function int pending();
            return pending_lines.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // position, first_value, second_value, zero fill
    logic [0:0]  s_axis_tuser = '0;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // digit_enables_n, segments_n

    display_scoreboard sb = new();
    bit  idle_on = 1'b0;
    int  cycles = 0;
    int  stall_left = 0;
    int  loads_sent = 0;
    int  scans_sent = 0;

    muxed_seven_segment_decimal_display_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: ready with random stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Record accepted items and check accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(req_t'(s_axis_tuser[0]), s_axis_tdata[2:0],
                             s_axis_tdata[18:3], s_axis_tdata[34:19]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_lines(m_axis_tdata);
        end
    end

    // Offer one item, after an optional idle burst, and wait for acceptance.
    task automatic send_item(req_t req, logic [POS_W-1:0] pos,
                             logic [VALUE_W-1:0] left_value,
                             logic [VALUE_W-1:0] right_value);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {5'b0, right_value, left_value, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (req == REQ_LOAD)
            loads_sent++;
        else
            scans_sent++;
    endtask

    // Value with a bias toward the mod-1000 boundaries.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return VALUE_W'($urandom_range(0, 9));
            1:       return VALUE_W'(1000 * $urandom_range(0, 65) + $urandom_range(995, 999));
            2:       return 16'hffff - VALUE_W'($urandom_range(0, 3));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // A load followed by a full scan sweep from a random start position.
    task automatic send_frame();
        logic [POS_W-1:0] start;
        start = POS_W'($urandom);
        send_item(REQ_LOAD, POS_W'($urandom), pick_value(), pick_value());
        for (int i = 0; i < DIGITS; i++)
            send_item(REQ_SCAN, start + POS_W'(i), VALUE_W'($urandom), VALUE_W'($urandom));
    endtask

    task automatic send_loose_item();
        if ($urandom_range(0, 3) == 0)
            send_item(REQ_LOAD, POS_W'($urandom), pick_value(), pick_value());
        else
            send_item(REQ_SCAN, POS_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom));
    endtask

    initial
    begin
        int sent_target;
        bit drained;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset contents, value extremes, ignored fields.
        for (int p = 0; p < DIGITS; p++)
            send_item(REQ_SCAN, POS_W'(p), '0, '0);
        send_item(REQ_LOAD, 3'd5, 16'd0, 16'hffff);
        for (int p = DIGITS - 1; p >= 0; p--)
            send_item(REQ_SCAN, POS_W'(p), '0, '0);
        send_item(REQ_LOAD, 3'd0, 16'd999, 16'd1000);
        for (int p = 1; p <= 3; p++)
            send_item(REQ_SCAN, POS_W'(p), 16'hffff, 16'hffff);
        send_item(REQ_LOAD, 3'd7, 16'd12345, 16'd678);
        send_item(REQ_SCAN, 3'd7, '0, '0);
        send_item(REQ_SCAN, 3'd0, '0, '0);

        // Random: mostly well-formed frames, some loose items.
        sent_target = loads_sent + scans_sent + RANDOM_ITEMS;
        drained = 1'b0;
        while (loads_sent + scans_sent < sent_target)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
                send_frame();
            else
                repeat ($urandom_range(1, 6)) send_loose_item();
            // Once mid-run, hold off until every result has come back.
            if (!drained && loads_sent + scans_sent > sent_target - RANDOM_ITEMS / 2)
            begin
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end

        // Final stretch at full rate on both sides.
        idle_on = 1'b0;
        send_frame();
        repeat (FINAL_ITEMS - 9) send_loose_item();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d loads and %0d scans; %0d results checked, %0d errors.",
                 loads_sent, scans_sent, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
